### src/rgs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgs_pkg
// shared types and register addresses of the roi gradient sharpness unit
// ----------------------------------------------------------------------------
package rgs_pkg;

  localparam int unsigned DivStages = 49;

  typedef enum logic [2:0] {
    RegWidth  = 3'd0,
    RegHeight = 3'd1,
    RegShrink = 3'd2,
    RegGap    = 3'd3,
    RegStep   = 3'd4,
    RegThresh = 3'd5
  } reg_addr_e;

  typedef enum logic [2:0] {
    SIdle,
    SLatch,
    SSearch,
    SRead,
    SUpd
  } smp_e;

  typedef struct packed {
    logic        start;
    logic [32:0] grad;
    logic [31:0] bright;
  } div_req_t;

endpackage

### src/rgs_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgs_divider
// restoring divider, one quotient bit per cycle, 16.16 saturating result
// ----------------------------------------------------------------------------
module rgs_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rgs_pkg::div_req_t req_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [32:0]       grad_o,
  output logic [31:0]       bright_o,
  output logic [31:0]       quot_o
);
  import rgs_pkg::*;

  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [48:0] num_q, num_d;
  logic [32:0] rem_q, rem_d;
  logic [48:0] quo_q, quo_d;
  logic [32:0] grad_q;
  logic [31:0] bright_q;
  logic [33:0] trial;

  assign trial = {rem_q, num_q[48]} - {2'b00, bright_q};

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    num_d  = num_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 6'(DivStages);
      num_d  = {req_i.grad, 16'h0};
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      num_d = {num_q[47:0], 1'b0};
      if (!trial[33]) begin
        rem_d = trial[32:0];
        quo_d = {quo_q[47:0], 1'b1};
      end else begin
        rem_d = {rem_q[31:0], num_q[48]};
        quo_d = {quo_q[47:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (req_i.start) begin
      grad_q   <= req_i.grad;
      bright_q <= req_i.bright;
    end
  end

  assign busy_o   = busy_q;
  assign done_o   = done_q;
  assign grad_o   = grad_q;
  assign bright_o = bright_q;
  assign quot_o   = (bright_q == '0) ? '0 :
                    (quo_q[48:32] != '0) ? 32'hFFFF_FFFF : quo_q[31:0];
endmodule

### src/roi_gradient_sharpness_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roi_gradient_sharpness_unit
// autofocus sharpness over left and right segments of a round image
//
// s_axis carries one luma sample per request in raster order (tdata[7:0]).
// m_axis carries one result per frame: tdata[32:0] gradient_sum,
// tdata[64:33] brightness_sum, tdata[96:65] sharpness, upper bits zero.
// The two previous lines live in two line memories with a registered read;
// each sample passes through accept, memory read and update in turn.
// Row half width is searched by a stepped square loop at the first pixel of
// a row: a latch state, then a search state that steps the estimate.
// After the last pixel of a frame the divider runs, and its result waits
// in an output register until taken. The next frame streams in
// meanwhile, but no pixel is taken while the divider runs, and the last
// pixel of a frame is held off while the output register is still full.
// Reset clears counters and sums; line memories are not cleared and are
// written before they are read in any legal frame.
// ----------------------------------------------------------------------------
module roi_gradient_sharpness_unit #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // luma
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [103:0] m_axis_tdata,  // gradient_sum, brightness_sum, sharpness, pad
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rgs_pkg::*;

  localparam int unsigned XW = $clog2(MAX_WIDTH);
  localparam int unsigned YW = $clog2(MAX_HEIGHT);

  logic [12:0] width_q, height_q;
  logic [10:0] shrink_q, gap_q;
  logic [7:0]  step_q, thresh_q;

  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 13'd640; height_q <= 13'd480; shrink_q <= 11'd30;
      gap_q <= 11'd120; step_q <= 8'd8; thresh_q <= 8'd5;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        RegWidth:  width_q  <= pwdata[12:0];
        RegHeight: height_q <= pwdata[12:0];
        RegShrink: shrink_q <= pwdata[10:0];
        RegGap:    gap_q    <= pwdata[10:0];
        RegStep:   step_q   <= pwdata[7:0];
        RegThresh: thresh_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[4:2])
      RegWidth:  prdata = {19'h0, width_q};
      RegHeight: prdata = {19'h0, height_q};
      RegShrink: prdata = {21'h0, shrink_q};
      RegGap:    prdata = {21'h0, gap_q};
      RegStep:   prdata = {24'h0, step_q};
      RegThresh: prdata = {24'h0, thresh_q};
      default:   prdata = '0;
    endcase
  end

  // effective geometry
  logic [13:0] w_eff, h_eff;
  assign w_eff = ({1'b0, width_q}  > 14'(MAX_WIDTH))  ? 14'(MAX_WIDTH)  : {1'b0, width_q};
  assign h_eff = ({1'b0, height_q} > 14'(MAX_HEIGHT)) ? 14'(MAX_HEIGHT) : {1'b0, height_q};

  logic signed [15:0] cy, rad, dd;
  assign cy  = 16'(h_eff >> 1);
  always_comb begin
    rad = cy - 16'sd10 - $signed({5'b0, shrink_q});
    if (rad < 16'sd1) rad = 16'sd1;
  end
  // floor(3r/5) via reciprocal: r <= 4086, 3r < 2^14
  logic [31:0] d_prod;
  assign d_prod = 32'(rad[13:0]) * 32'd3 * 32'd13108;
  assign dd = 16'(d_prod >> 16);

  // state
  logic [13:0] col_q, row_q;
  logic        active_q;
  logic [12:0] hw_q;
  logic [33:0] gacc_q;
  logic [32:0] bacc_q;
  logic [7:0]  n1_q;

  logic [7:0] mem_one [MAX_WIDTH];
  logic [7:0] mem_two [MAX_WIDTH];
  logic [7:0] rd_one_a, rd_one_b, rd_two;

  // sample sequencer
  smp_e st_q, st_d;
  logic [7:0]  lum_q;
  logic [24:0] est_q;
  logic [25:0] rem_q;
  logic [49:0] est_sq;
  logic [7:0]  s_eff;

  assign s_eff  = (step_q == 8'd0) ? 8'd1 : step_q;
  assign est_sq = 50'(est_q) * 50'(est_q);

  logic [13:0] y_c;
  logic signed [15:0] dyv;
  logic win_ok;
  assign y_c = row_q - 14'd1;
  assign dyv = $signed({2'b0, y_c}) - cy;
  assign win_ok = (row_q != '0) &&
                  ($signed({2'b0, y_c}) > cy - dd) && ($signed({2'b0, y_c}) < cy + dd) &&
                  (y_c >= 14'd1) && ({2'b0, y_c} + 16'd2 <= {2'b0, h_eff});
  logic signed [31:0] remv;
  assign remv = rad * rad - dyv * dyv;

  logic div_busy, div_done;
  logic [32:0] dgrad;
  logic [31:0] dbright, dquot;
  div_req_t dreq;
  logic out_v_q;
  logic [32:0] og_q;
  logic [31:0] ob_q, oq_q;

  logic last_col, last_row;
  assign last_col = (col_q + 14'd1 >= w_eff);
  assign last_row = (row_q + 14'd1 >= h_eff);

  // last pixel of a frame waits for a free output register
  assign s_axis_tready = (st_q == SIdle) && !div_busy && !div_done && !dreq.start &&
                         !(out_v_q && last_col && last_row);

  logic acc_go;
  assign acc_go = s_axis_tvalid && s_axis_tready;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      SIdle:   if (acc_go) st_d = (col_q == '0) ? SLatch : SRead;
      SLatch:  st_d = win_ok && (remv > 0) ? SSearch : SRead;
      SSearch: if (est_sq >= 50'(rem_q)) st_d = SRead;
      SRead:   st_d = SUpd;
      SUpd:    st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  logic [XW-1:0] xi;
  assign xi = col_q[XW-1:0];
  logic nxt_ok;
  assign nxt_ok = (col_q + 14'd1 < w_eff) && (32'(col_q) + 32'd1 < 32'(MAX_WIDTH));

  always_ff @(posedge clk_i) begin
    rd_one_a <= mem_one[xi];
    rd_one_b <= mem_one[nxt_ok ? xi + XW'(1) : xi];
    rd_two   <= mem_two[xi];
    if (st_q == SUpd) begin
      mem_two[xi] <= rd_one_a;
      mem_one[xi] <= lum_q;
    end
    if (acc_go) lum_q <= s_axis_tdata;
  end

  // segment and accumulate
  logic signed [15:0] cx, hwv, gv, l0, l1, r0, r1, xs, wm2;
  logic [1:0] mult;
  logic [7:0] gx, gy, nb0, nb1, nb2;
  assign nb0 = n1_q;
  assign nb1 = rd_one_a;
  assign nb2 = nxt_ok ? rd_one_b : 8'd0;
  always_comb begin
    cx  = 16'(w_eff >> 1);
    hwv = {3'b0, hw_q};
    gv  = {5'b0, gap_q};
    wm2 = $signed({2'b0, w_eff}) - 16'sd2;
    xs  = {2'b0, col_q};
    l0 = cx - hwv; l1 = cx - gv; r0 = cx + gv; r1 = cx + hwv;
    if (l0 < 16'sd1) l0 = 16'sd1;
    if (l1 > wm2) l1 = wm2;
    if (r0 < 16'sd1) r0 = 16'sd1;
    if (r1 > wm2) r1 = wm2;
    mult = 2'd0;
    if (active_q && xs >= 16'sd1 && xs <= wm2) begin
      if (xs >= l0 && xs <= l1) mult = mult + 2'd1;
      if (xs >= r0 && xs <= r1) mult = mult + 2'd1;
    end
    gx = (nb2 > nb0) ? nb2 - nb0 : nb0 - nb2;
    gy = (lum_q > rd_two) ? lum_q - rd_two : rd_two - lum_q;
  end

  logic [10:0] gadd;
  logic [9:0]  badd;
  logic [34:0] gsum;
  logic [33:0] bsum;
  always_comb begin
    gadd = '0;
    if (gx >= thresh_q) gadd = gadd + 11'(gx);
    if (gy >= thresh_q) gadd = gadd + 11'(gy);
    gadd = (mult == 2'd2) ? gadd << 1 : (mult == 2'd1 ? gadd : '0);
    badd = (mult == 2'd2) ? {1'b0, nb1, 1'b0} : (mult == 2'd1 ? 10'(nb1) : '0);
    gsum = 35'(gacc_q) + 35'(gadd);
    bsum = 34'(bacc_q) + 34'(badd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; col_q <= '0; row_q <= '0; active_q <= 1'b0; hw_q <= '0;
      gacc_q <= '0; bacc_q <= '0; n1_q <= '0;
      est_q <= '0; rem_q <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == SLatch) begin
        active_q <= 1'b0; hw_q <= '0;
        est_q <= '0; rem_q <= 26'(remv);
      end
      if (st_q == SSearch) begin
        if (est_sq >= 50'(rem_q)) begin
          hw_q <= 13'(est_q - 25'(s_eff)); active_q <= 1'b1;
        end else est_q <= est_q + 25'(s_eff);
      end
      if (st_q == SUpd) begin
        n1_q <= nb1;
        gacc_q <= (gsum > 35'h1_FFFF_FFFF) ? 34'h1_FFFF_FFFF : gsum[33:0];
        bacc_q <= (bsum > 34'hFFFF_FFFF) ? 33'hFFFF_FFFF : bsum[32:0];
        if (!last_col) col_q <= col_q + 14'd1;
        else begin
          col_q <= '0;
          if (!last_row) row_q <= row_q + 14'd1;
          else begin
            row_q <= '0; gacc_q <= '0; bacc_q <= '0;
          end
        end
      end
    end
  end

  assign dreq.start  = (st_q == SUpd) && last_col && last_row;
  assign dreq.grad   = (gsum > 35'h1_FFFF_FFFF) ? 33'h1_FFFF_FFFF : gsum[32:0];
  assign dreq.bright = (bsum > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : bsum[31:0];

  rgs_divider u_div (
    .clk_i, .rst_ni, .req_i(dreq), .busy_o(div_busy), .done_o(div_done),
    .grad_o(dgrad), .bright_o(dbright), .quot_o(dquot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (div_done) out_v_q <= 1'b1;
    else if (m_axis_tready) out_v_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (div_done) begin
      og_q <= dgrad; ob_q <= dbright; oq_q <= dquot;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {7'h0, oq_q, ob_q, og_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !div_busy && !div_done) else $error("input open while dividing");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready && out_v_q |-> !(last_col && last_row))
    else $error("frame end accepted while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dreq.start |=> div_busy) else $error("divider did not start");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == SUpd) |-> $past(st_q) == SRead) else $error("update without memory read");
endmodule

### tb/rgs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgs_checker
// Predicts the per-frame focus result of roi_gradient_sharpness_unit from the
// observed register writes and accepted luma requests. Each accepted result
// is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module rgs_checker
  import rgs_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [103:0] m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  output int           fail_count,
  output int           pending
);

  localparam int unsigned LineLen = 4096;
  localparam longint GradLimit   = 64'h1_FFFF_FFFF;
  localparam longint BrightLimit = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [32:0] grad;
    logic [31:0] bright;
    logic [31:0] sharp;
  } focus_result_t;

  focus_result_t focus_q[$];

  logic [12:0] cfg_width, cfg_height;
  logic [10:0] cfg_shrink, cfg_gap;
  logic [7:0]  cfg_step, cfg_thresh;

  logic [7:0] line_prev2 [LineLen];
  logic [7:0] line_prev1 [LineLen];
  int unsigned col_cnt, row_cnt;
  longint      half_width;
  logic        row_on;
  longint      grad_acc, bright_acc;
  logic [7:0]  win [3];

  function automatic longint eff_size(logic [12:0] v);
    return (v > LineLen) ? LineLen : longint'(v);
  endfunction

  function automatic void latch_row(longint y);
    longint hgt, cy, rad, dlim, dy, rem, est, stp;
    hgt = eff_size(cfg_height);
    cy = hgt / 2;
    rad = hgt / 2 - 10 - longint'(cfg_shrink);
    if (rad < 1) rad = 1;
    dlim = (3 * rad) / 5;
    row_on = 1'b0;
    half_width = 0;
    if (y <= cy - dlim || y >= cy + dlim || y < 1 || y > hgt - 2) return;
    dy = y - cy;
    rem = rad * rad - dy * dy;
    if (rem <= 0) return;
    stp = (cfg_step == 0) ? 1 : longint'(cfg_step);
    est = 0;
    while (est * est < rem) est += stp;
    half_width = est - stp;
    row_on = 1'b1;
  endfunction

  function automatic void take_pixel(logic [7:0] cur);
    longint wd, hgt, x, cx, l0, l1, r0, r1, gx, gy;
    int unsigned xi;
    int mult;
    focus_result_t res;
    wd = eff_size(cfg_width);
    hgt = eff_size(cfg_height);
    x = longint'(col_cnt);
    xi = col_cnt % LineLen;
    if (col_cnt == 0) begin
      if (row_cnt >= 1) latch_row(longint'(row_cnt) - 1);
      else begin
        row_on = 1'b0;
        half_width = 0;
      end
    end
    win[0] = win[1];
    win[1] = line_prev1[xi];
    win[2] = (x + 1 < wd && xi + 1 < LineLen) ? line_prev1[xi+1] : 8'd0;
    if (row_on && x >= 1 && x <= wd - 2) begin
      cx = wd / 2;
      l0 = cx - half_width;
      l1 = cx - longint'(cfg_gap);
      r0 = cx + longint'(cfg_gap);
      r1 = cx + half_width;
      if (l0 < 1) l0 = 1;
      if (l1 > wd - 2) l1 = wd - 2;
      if (r0 < 1) r0 = 1;
      if (r1 > wd - 2) r1 = wd - 2;
      mult = 0;
      if (x >= l0 && x <= l1) mult++;
      if (x >= r0 && x <= r1) mult++;
      gx = longint'(win[2]) - longint'(win[0]);
      gy = longint'(cur) - longint'(line_prev2[xi]);
      if (gx < 0) gx = -gx;
      if (gy < 0) gy = -gy;
      for (int k = 0; k < mult; k++) begin
        if (gx >= longint'(cfg_thresh)) grad_acc += gx;
        if (gy >= longint'(cfg_thresh)) grad_acc += gy;
        if (grad_acc > GradLimit) grad_acc = GradLimit;
        bright_acc += longint'(win[1]);
        if (bright_acc > BrightLimit) bright_acc = BrightLimit;
      end
    end
    line_prev2[xi] = win[1];
    line_prev1[xi] = cur;
    if (x + 1 < wd) begin
      col_cnt++;
      return;
    end
    col_cnt = 0;
    if (longint'(row_cnt) + 1 < hgt) begin
      row_cnt++;
      return;
    end
    row_cnt = 0;
    res.grad = grad_acc[32:0];
    res.bright = bright_acc[31:0];
    res.sharp = '0;
    if (bright_acc != 0) begin
      longint q;
      q = (grad_acc << 16) / bright_acc;
      res.sharp = (q > BrightLimit) ? 32'hFFFF_FFFF : q[31:0];
    end
    focus_q.push_back(res);
    grad_acc = 0;
    bright_acc = 0;
  endfunction

  always @(posedge clk_i) begin
    focus_result_t got, want;
    if (!rst_ni) begin
      fail_count = 0;
      pending = 0;
      focus_q.delete();
      cfg_width = 13'd640;
      cfg_height = 13'd480;
      cfg_shrink = 11'd30;
      cfg_gap = 11'd120;
      cfg_step = 8'd8;
      cfg_thresh = 8'd5;
      col_cnt = 0;
      row_cnt = 0;
      half_width = 0;
      row_on = 1'b0;
      grad_acc = 0;
      bright_acc = 0;
      for (int i = 0; i < 3; i++) win[i] = 8'd0;
      for (int i = 0; i < LineLen; i++) begin
        line_prev1[i] = 8'd0;
        line_prev2[i] = 8'd0;
      end
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_addr_e'(paddr[4:2]))
          RegWidth:  cfg_width  = pwdata[12:0];
          RegHeight: cfg_height = pwdata[12:0];
          RegShrink: cfg_shrink = pwdata[10:0];
          RegGap:    cfg_gap    = pwdata[10:0];
          RegStep:   cfg_step   = pwdata[7:0];
          RegThresh: cfg_thresh = pwdata[7:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) take_pixel(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        got.grad = m_axis_tdata[32:0];
        got.bright = m_axis_tdata[64:33];
        got.sharp = m_axis_tdata[96:65];
        if (focus_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          fail_count++;
        end else begin
          want = focus_q.pop_front();
          if (got.grad !== want.grad) begin
            $display("%0t: gradient_sum expected %0h actual %0h", $time, want.grad, got.grad);
            fail_count++;
          end
          if (got.bright !== want.bright) begin
            $display("%0t: brightness_sum expected %0h actual %0h", $time, want.bright,
                     got.bright);
            fail_count++;
          end
          if (got.sharp !== want.sharp) begin
            $display("%0t: sharpness expected %0h actual %0h", $time, want.sharp, got.sharp);
            fail_count++;
          end
        end
      end
      pending = focus_q.size();
    end
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives whole luma frames into roi_gradient_sharpness_unit under a range of
// geometries, thresholds and steps, with random idle bursts on both streams,
// a long result hold-off and quiet pauses; rgs_checker judges every result.
// ----------------------------------------------------------------------------
module testbench;
  import rgs_pkg::*;

  localparam int CycleLimit = 2_000_000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  int  fail_count, pending;
  bit  idle_en = 1'b1;
  bit  hold_active = 1'b0;
  int  stall_left = 0;
  int  cycle_cnt = 0;
  event start_hold;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  roi_gradient_sharpness_unit dut (.*);

  rgs_checker u_checker (.*);

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial forever begin
    @start_hold;
    hold_active = 1'b1;
    repeat (400) @(negedge clk_i);
    hold_active = 1'b0;
  end

  // result side back-pressure
  always @(negedge clk_i) begin
    if (hold_active) m_axis_tready <= 1'b0;
    else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left = $urandom_range(0, 9);
    end else m_axis_tready <= 1'b1;
  end

  task automatic reg_write(reg_addr_e idx, int unsigned val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    wait (pending == 0);
    repeat (DivStages + 20) @(negedge clk_i);
  endtask

  task automatic set_geometry(int w, int h, int shrink, int gap, int stp, int thr);
    wait_drained();
    reg_write(RegWidth, w);
    reg_write(RegHeight, h);
    reg_write(RegShrink, shrink);
    reg_write(RegGap, gap);
    reg_write(RegStep, stp);
    reg_write(RegThresh, thr);
  endtask

  // returns at the accepting edge
  task automatic send_pixel(logic [7:0] v);
    @(negedge clk_i);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= v;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic stop_send();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  // pattern: 0 random, 1 checkerboard of extremes, 2 all white, 3 all black
  task automatic send_frame(int w, int h, int pattern);
    int wp, hp;
    logic [7:0] v;
    wp = (w <= 1) ? 1 : ((w > 4096) ? 4096 : w);
    hp = (h <= 1) ? 1 : ((h > 4096) ? 4096 : h);
    for (int y = 0; y < hp; y++) begin
      for (int x = 0; x < wp; x++) begin
        case (pattern)
          1: v = ((x + y) % 2 == 1) ? 8'hFF : 8'h00;
          2: v = 8'hFF;
          3: v = 8'h00;
          default: v = 8'($urandom_range(0, 255));
        endcase
        send_pixel(v);
      end
    end
    stop_send();
  endtask

  initial begin
    int w, h;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: degenerate frames, extremes, double counted center column
    set_geometry(0, 0, 0, 0, 0, 0);
    send_frame(0, 0, 2);
    send_frame(0, 0, 3);
    set_geometry(5, 1, 0, 0, 1, 255);
    send_frame(5, 1, 1);
    set_geometry(1, 24, 0, 0, 1, 0);
    send_frame(1, 24, 0);
    set_geometry(6, 24, 0, 0, 1, 0);
    send_frame(6, 24, 1);
    set_geometry(6, 24, 0, 2047, 255, 255);
    send_frame(6, 24, 2);
    set_geometry(6, 24, 0, 1, 0, 1);
    send_frame(6, 24, 0);

    // long result hold-off while the sender keeps offering
    set_geometry(0, 0, 0, 0, 1, 0);
    -> start_hold;
    for (int i = 0; i < 20; i++) send_pixel(8'($urandom_range(0, 255)));
    stop_send();

    // random geometries, small well-formed frames
    for (int p = 0; p < 3; p++) begin
      if (p == 2) idle_en = 1'b0;
      w = $urandom_range(4, 5);
      h = $urandom_range(24, 40);
      set_geometry(w, h, $urandom_range(0, 6), $urandom_range(0, 8),
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                               : $urandom_range(1, 4),
                   $urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                             : $urandom_range(0, 40));
      send_frame(w, h, ($urandom_range(0, 7) == 0) ? 1 : 0);
    end

    wait (pending == 0);
    repeat (DivStages * 2 + 20) @(negedge clk_i);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
